FILE: rtl/core/ubxfp_pkg.sv
`default_nettype none

package ubxfp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned TDATA_W = 72;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hB5;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h62;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SYNC_FIRST  = 1'b0,
		CFG_SYNC_SECOND = 1'b1
	} cfg_index_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_SUM_GOOD = 2'd1,
		KIND_SUM_BAD  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] frame_class;
		logic [BYTE_W-1:0] frame_id;
		logic [LEN_W-1:0]  frame_length;
		logic [LEN_W-1:0]  byte_index;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] sum_a_received;
		logic [BYTE_W-1:0] sum_b_received;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/ubxfp_parser.sv
`default_nettype none

module ubxfp_parser
	import ubxfp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0] cfg_data,
	input  wire logic              fire,
	input  wire logic [BYTE_W-1:0] data_s1,
	output logic                   res_valid,
	output result_t                res
);

	typedef enum logic [3:0] {
		PH_HUNT1   = 4'd0,
		PH_HUNT2   = 4'd1,
		PH_CLASS   = 4'd2,
		PH_ID      = 4'd3,
		PH_LENLO   = 4'd4,
		PH_LENHI   = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_SUMA    = 4'd7,
		PH_SUMB    = 4'd8
	} phase_t;

	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] class_q, class_d;
	logic [BYTE_W-1:0] id_q, id_d;
	logic [LEN_W-1:0]  length_q, length_d;
	logic [LEN_W-1:0]  count_q, count_d;
	logic [BYTE_W-1:0] sum_a_q, sum_a_d;
	logic [BYTE_W-1:0] sum_b_q, sum_b_d;
	logic [BYTE_W-1:0] cap_a_q, cap_a_d;
	logic [BYTE_W-1:0] acc_a;
	logic [BYTE_W-1:0] acc_b;
	logic [LEN_W-1:0]  count_inc;
	logic              has_result;

	assign acc_a     = sum_a_q + data_s1;
	assign acc_b     = sum_b_q + acc_a;
	assign count_inc = count_q + LEN_W'(1);

	always_comb begin
		phase_d    = phase_q;
		class_d    = class_q;
		id_d       = id_q;
		length_d   = length_q;
		count_d    = count_q;
		sum_a_d    = sum_a_q;
		sum_b_d    = sum_b_q;
		cap_a_d    = cap_a_q;
		has_result = 1'b0;
		res.kind           = KIND_PAYLOAD;
		res.frame_class    = class_q;
		res.frame_id       = id_q;
		res.frame_length   = length_q;
		res.byte_index     = '0;
		res.payload_byte   = '0;
		res.sum_a_received = '0;
		res.sum_b_received = '0;
		case (phase_q)
			PH_HUNT1: begin
				if (data_s1 == sync_first_q)
					phase_d = PH_HUNT2;
			end
			PH_HUNT2: begin
				if (data_s1 == sync_second_q) begin
					phase_d = PH_CLASS;
					sum_a_d = '0;
					sum_b_d = '0;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_CLASS: begin
				class_d = data_s1;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				phase_d = PH_ID;
			end
			PH_ID: begin
				id_d    = data_s1;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				length_d = {{(LEN_W-BYTE_W){1'b0}}, data_s1};
				sum_a_d  = acc_a;
				sum_b_d  = acc_b;
				phase_d  = PH_LENHI;
			end
			PH_LENHI: begin
				length_d = {data_s1, length_q[BYTE_W-1:0]};
				sum_a_d  = acc_a;
				sum_b_d  = acc_b;
				count_d  = '0;
				phase_d  = ({data_s1, length_q[BYTE_W-1:0]} == '0) ? PH_SUMA : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_a_d    = acc_a;
				sum_b_d    = acc_b;
				count_d    = count_inc;
				if (count_inc == length_q)
					phase_d = PH_SUMA;
				has_result       = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.byte_index   = count_q;
				res.payload_byte = data_s1;
			end
			PH_SUMA: begin
				cap_a_d = data_s1;
				phase_d = PH_SUMB;
			end
			PH_SUMB: begin
				phase_d            = PH_HUNT1;
				has_result         = 1'b1;
				res.kind           = ((cap_a_q == sum_a_q) && (data_s1 == sum_b_q)) ?
					KIND_SUM_GOOD : KIND_SUM_BAD;
				res.sum_a_received = cap_a_q;
				res.sum_b_received = data_s1;
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
	end

	assign res_valid = fire && has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			phase_q       <= PH_HUNT1;
			class_q       <= '0;
			id_q          <= '0;
			length_q      <= '0;
			count_q       <= '0;
			sum_a_q       <= '0;
			sum_b_q       <= '0;
			cap_a_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
					CFG_SYNC_SECOND: sync_second_q <= cfg_data;
					default: ;
				endcase
			end
			if (fire) begin
				phase_q  <= phase_d;
				class_q  <= class_d;
				id_q     <= id_d;
				length_q <= length_d;
				count_q  <= count_d;
				sum_a_q  <= sum_a_d;
				sum_b_q  <= sum_b_d;
				cap_a_q  <= cap_a_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_fire_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q))
		else $error("frame phase changed without a consumed byte");
	a_sumb_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q == PH_SUMB) |=> phase_q == PH_HUNT1)
		else $error("parser did not return to hunt after the second checksum byte");
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (count_q < length_q))
		else $error("payload count reached the declared length while still in payload");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ubxfp_skid.sv
`default_nettype none

module ubxfp_skid
	import ubxfp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire result_t in_res,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_res
);

	logic    main_v_q;
	logic    skid_v_q;
	result_t main_q;
	result_t skid_q;

	assign in_ready  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !main_v_q) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= in_valid;
			end
		end else if (in_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !main_v_q) begin
			if (skid_v_q)
				main_q <= skid_q;
			else if (in_valid)
				main_q <= in_res;
		end else if (in_valid && !skid_v_q) begin
			skid_q <= in_res;
		end
	end

`ifndef SYNTHESIS
	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry held while the output register is empty");
	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(in_valid && main_v_q && !out_ready))
		else $error("skid entry filled without a stalled output");
	a_skid_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !in_ready)
		else $error("new result offered while the skid entry is full");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ubx_frame_parser.sv
// Frame parser for a two-sync-byte binary serial protocol with an 8-bit
// two-sum checksum. Received bytes enter on the s_ group, one byte per
// transfer. Each payload byte leaves on the m_ group with the frame's class,
// id, declared length and its index; after the two checksum bytes a
// frame-end transfer reports a good or bad checksum in m_tuser.
// A byte is registered at the input and processed once the output side has
// room for a result; results are registered in the output register. One
// byte per cycle is sustained while m_tready stays high; the checksum update
// is one add pair, combinational on the input register's byte. The user
// must write sync values through cfg_we, cfg_index and cfg_data only while
// the block is idle; the block itself does not enforce this. Reset restores
// the default sync values and returns the parser to hunting the first sync
// byte with all frame state cleared. When the receiver stalls, the output
// register and a one-entry skid buffer absorb results; once both are full,
// the next byte waits in the input register and s_tready falls. No byte or
// result is lost or repeated.
`default_nettype none

module ubx_frame_parser
	import ubxfp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [BYTE_W-1:0]    s_tdata,   // data_in
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// frame_class, frame_id, frame_length, byte_index, payload_byte,
	// sum_a_received, sum_b_received
	output logic [TDATA_W-1:0]        m_tdata,
	output logic [KIND_W-1:0]         m_tuser    // kind
);

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              out_free;
	logic              fire;
	logic              res_valid;
	result_t           res;
	result_t           out_res;

	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			data_s1 <= s_tdata;
	end

	ubxfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.data_s1   (data_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ubxfp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (out_free),
		.in_res    (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tuser = out_res.kind;
	assign m_tdata = {out_res.sum_b_received, out_res.sum_a_received, out_res.payload_byte,
		out_res.byte_index, out_res.frame_length, out_res.frame_id, out_res.frame_class};

endmodule

`default_nettype wire

FILE: test/ubx_frame_parser_checker.sv
`default_nettype none

module ubx_frame_parser_checker
	import ubxfp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [BYTE_W-1:0]    s_tdata,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [TDATA_W-1:0]   m_tdata,
	input  wire logic [KIND_W-1:0]    m_tuser,
	output int                        fail_count,
	output int                        pending,
	output int                        results_seen,
	output int                        good_ends,
	output int                        bad_ends
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		ST_HUNT_FIRST  = 4'd0,
		ST_HUNT_SECOND = 4'd1,
		ST_CLASS       = 4'd2,
		ST_ID          = 4'd3,
		ST_LEN_LO      = 4'd4,
		ST_LEN_HI      = 4'd5,
		ST_PAYLOAD     = 4'd6,
		ST_SUM_A       = 4'd7,
		ST_SUM_B       = 4'd8
	} parse_state_t;

	logic [BYTE_W-1:0] sync_first_val;
	logic [BYTE_W-1:0] sync_second_val;
	parse_state_t      parse_state;
	logic [BYTE_W-1:0] class_q;
	logic [BYTE_W-1:0] id_q;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  payload_count;
	logic [BYTE_W-1:0] sum_a_run;
	logic [BYTE_W-1:0] sum_b_run;
	logic [BYTE_W-1:0] sum_a_got;
	result_t           frame_results[$];

	task automatic fold_checksum(input logic [BYTE_W-1:0] b);
		sum_a_run = sum_a_run + b;
		sum_b_run = sum_b_run + sum_a_run;
	endtask

	task automatic predict_byte(input logic [BYTE_W-1:0] b);
		result_t r;
		r = '0;
		r.frame_class  = class_q;
		r.frame_id     = id_q;
		r.frame_length = length_q;
		case (parse_state)
			ST_HUNT_FIRST: begin
				if (b == sync_first_val)
					parse_state = ST_HUNT_SECOND;
			end
			ST_HUNT_SECOND: begin
				if (b == sync_second_val) begin
					parse_state = ST_CLASS;
					sum_a_run = '0;
					sum_b_run = '0;
				end else begin
					parse_state = ST_HUNT_FIRST;
				end
			end
			ST_CLASS: begin
				class_q = b;
				fold_checksum(b);
				parse_state = ST_ID;
			end
			ST_ID: begin
				id_q = b;
				fold_checksum(b);
				parse_state = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				length_q = {8'h00, b};
				fold_checksum(b);
				parse_state = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				length_q[15:8] = b;
				fold_checksum(b);
				payload_count = '0;
				parse_state = (length_q == '0) ? ST_SUM_A : ST_PAYLOAD;
			end
			ST_PAYLOAD: begin
				r.kind = KIND_PAYLOAD;
				r.byte_index = payload_count;
				r.payload_byte = b;
				fold_checksum(b);
				payload_count = payload_count + 1'b1;
				if (payload_count == length_q)
					parse_state = ST_SUM_A;
				frame_results.push_back(r);
			end
			ST_SUM_A: begin
				sum_a_got = b;
				parse_state = ST_SUM_B;
			end
			ST_SUM_B: begin
				r.kind = (sum_a_got == sum_a_run && b == sum_b_run) ? KIND_SUM_GOOD : KIND_SUM_BAD;
				r.sum_a_received = sum_a_got;
				r.sum_b_received = b;
				frame_results.push_back(r);
				parse_state = ST_HUNT_FIRST;
			end
			default: begin
				parse_state = ST_HUNT_FIRST;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		result_t want;
		results_seen++;
		if (m_tuser == KIND_SUM_GOOD)
			good_ends++;
		else if (m_tuser == KIND_SUM_BAD)
			bad_ends++;
		if (frame_results.size() == 0) begin
			$error("unexpected result transfer: kind %0d, data %0h", m_tuser, m_tdata);
			fail_count++;
		end else begin
			want = frame_results.pop_front();
			check_field("kind", want.kind, m_tuser);
			check_field("frame_class", want.frame_class, m_tdata[7:0]);
			check_field("frame_id", want.frame_id, m_tdata[15:8]);
			check_field("frame_length", want.frame_length, m_tdata[31:16]);
			check_field("byte_index", want.byte_index, m_tdata[47:32]);
			check_field("payload_byte", want.payload_byte, m_tdata[55:48]);
			check_field("sum_a_received", want.sum_a_received, m_tdata[63:56]);
			check_field("sum_b_received", want.sum_b_received, m_tdata[71:64]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_val = SYNC_FIRST_RST;
			sync_second_val = SYNC_SECOND_RST;
			parse_state = ST_HUNT_FIRST;
			class_q = '0;
			id_q = '0;
			length_q = '0;
			payload_count = '0;
			sum_a_run = '0;
			sum_b_run = '0;
			sum_a_got = '0;
			frame_results.delete();
			fail_count = 0;
			pending = 0;
			results_seen = 0;
			good_ends = 0;
			bad_ends = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				predict_byte(s_tdata);
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_SYNC_FIRST: sync_first_val = cfg_data;
					CFG_SYNC_SECOND: sync_second_val = cfg_data;
					default: ;
				endcase
			end
			pending = frame_results.size();
		end
	end

endmodule

`default_nettype wire

FILE: test/ubx_frame_parser_test.sv
`default_nettype none

module ubx_frame_parser_test;
	import ubxfp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_BYTES = 410;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_FIRST;
	logic [BYTE_W-1:0]    cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b1;
	logic [TDATA_W-1:0]   m_tdata;
	logic [KIND_W-1:0]    m_tuser;

	int fail_count;
	int pending;
	int results_seen;
	int good_ends;
	int bad_ends;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int bytes_sent = 0;
	int phase_start;
	int pick;
	int ph;
	logic [LEN_W-1:0]  frame_len;
	logic [BYTE_W-1:0] sync_a_cur = SYNC_FIRST_RST;
	logic [BYTE_W-1:0] sync_b_cur = SYNC_SECOND_RST;
	logic [BYTE_W-1:0] frame_sum_a;
	logic [BYTE_W-1:0] frame_sum_b;

	logic [BYTE_W-1:0] directed_bytes[] = '{
		8'h00, 8'hB5, 8'hB5, 8'hB5, 8'h62, 8'hFF, 8'h00, 8'h02, 8'h00, 8'h80, 8'h7F,
		8'h00, 8'h81, 8'hB5, 8'h62, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFC
	};

	ubx_frame_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	ubx_frame_parser_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.good_ends    (good_ends),
		.bad_ends     (bad_ends)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ubx_frame_parser test failed");
			$finish;
		end
	end

	function automatic logic [BYTE_W-1:0] random_byte_except(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] b;
		b = 8'($urandom);
		while (b == v)
			b = 8'($urandom);
		return b;
	endfunction

	// Called right after a rising edge; returns right after the edge of the transfer.
	task automatic put_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic put_summed(input logic [BYTE_W-1:0] b);
		frame_sum_a = frame_sum_a + b;
		frame_sum_b = frame_sum_b + frame_sum_a;
		put_byte(b);
	endtask

	task automatic put_frame(input logic [LEN_W-1:0] len, input logic bad_sum);
		logic [BYTE_W-1:0] sa;
		logic [BYTE_W-1:0] sb;
		frame_sum_a = '0;
		frame_sum_b = '0;
		put_byte(sync_a_cur);
		put_byte(sync_b_cur);
		put_summed(8'($urandom));
		put_summed(8'($urandom));
		put_summed(len[7:0]);
		put_summed(len[15:8]);
		for (int i = 0; i < len; i++)
			put_summed(8'($urandom));
		sa = frame_sum_a;
		sb = frame_sum_b;
		if (bad_sum) begin
			case ($urandom_range(2))
				0: sa = sa ^ 8'($urandom_range(1, 255));
				1: sb = sb ^ 8'($urandom_range(1, 255));
				default: begin
					sa = sa ^ 8'($urandom_range(1, 255));
					sb = sb ^ 8'($urandom_range(1, 255));
				end
			endcase
		end
		put_byte(sa);
		put_byte(sb);
	endtask

	task automatic set_syncs(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SYNC_FIRST;
		cfg_data <= first;
		@(posedge clk);
		cfg_index <= CFG_SYNC_SECOND;
		cfg_data <= second;
		@(posedge clk);
		cfg_we <= 1'b0;
		sync_a_cur = first;
		sync_b_cur = second;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_bytes[i])
			put_byte(directed_bytes[i]);

		for (ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
					set_syncs(8'($urandom), 8'($urandom));
				end
				1: begin
					send_idle_pct = 67;
					recv_stall_pct <= 0;
					set_syncs(8'h00, 8'hFF);
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 67;
					set_syncs(8'hFF, 8'h00);
				end
				default: begin
					send_idle_pct = 21;
					recv_stall_pct <= 21;
					pick = $urandom_range(255);
					set_syncs(8'(pick), 8'(pick));
				end
			endcase

			// Mostly well-formed frames, with some corrupted sums, failed
			// sync pairs and noise bytes that leave the parser hunting.
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				pick = $urandom_range(99);
				if (pick < 82) begin
					case ($urandom_range(99)) inside
						[0:14]: frame_len = '0;
						[15:84]: frame_len = 16'($urandom_range(1, 8));
						[85:96]: frame_len = 16'($urandom_range(9, 40));
						default: frame_len = 16'($urandom_range(41, 300));
					endcase
					put_frame(frame_len, pick >= 70);
				end else if (pick < 90) begin
					put_byte(sync_a_cur);
					put_byte(random_byte_except(sync_b_cur));
				end else begin
					repeat ($urandom_range(1, 4))
						put_byte(random_byte_except(sync_a_cur));
				end
			end
		end

		settle();
		$display("Sent %0d bytes under four sync settings and four idle patterns,",
			bytes_sent);
		$display("with empty and long payloads; %0d results checked, %0d good and %0d bad frame ends.",
			results_seen, good_ends, bad_ends);
		if (fail_count == 0 && pending == 0)
			$display("ubx_frame_parser test passed");
		else
			$display("ubx_frame_parser test failed");
		$finish;
	end

endmodule

`default_nettype wire
